### hw/rtl/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared constants, codes and types of the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

  localparam int unsigned PAGE_COUNT = 4096;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned BIT_AW     = $clog2(WORD_BITS);
  localparam int unsigned WORD_COUNT = PAGE_COUNT / WORD_BITS;
  localparam int unsigned WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned PAGE_LIMIT = WORD_COUNT * WORD_BITS;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned STAT_W     = 2;

  localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_RANGE   = 2'd2
  } status_t;

  // access request from the sequencer to the bitmap store
  typedef struct packed {
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } map_req_t;

  // result of the shared bit unit
  typedef struct packed {
    logic                 full;
    logic [BIT_AW-1:0]    low_bit;
    logic [WORD_BITS-1:0] new_word;
  } bit_res_t;

endpackage

### hw/rtl/pfba_map.sv
// ----------------------------------------------------------------------------
// pfba_map
// Used-page bitmap store: one word written and one word read per cycle,
// registered read data, per-word valid bits so that reset frees every page.
// ----------------------------------------------------------------------------
module pfba_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfba_pkg::map_req_t            req,
  output logic [pfba_pkg::WORD_BITS-1:0] rd_word
);
  import pfba_pkg::*;

  logic [WORD_BITS-1:0]  mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] valid_r;
  logic [WORD_BITS-1:0]  rd_data_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr];
      end
    end
  end

  // a word never written since reset reads as all free
  assign rd_word = rd_vld_r ? rd_data_r : '0;

endmodule

### hw/rtl/pfba_bit_unit.sv
// ----------------------------------------------------------------------------
// pfba_bit_unit
// Shared word unit: full-word compare, lowest clear bit search and the
// single-bit set or clear of the word being updated.
// ----------------------------------------------------------------------------
module pfba_bit_unit (
  input  logic [pfba_pkg::WORD_BITS-1:0] word,
  input  logic                           op,
  input  logic [pfba_pkg::BIT_AW-1:0]    bit_sel,
  output pfba_pkg::bit_res_t             res
);
  import pfba_pkg::*;

  logic [BIT_AW-1:0]    low;
  logic [BIT_AW-1:0]    sh_amt;
  logic [WORD_BITS-1:0] mask;

  always_comb begin
    low = BIT_AW'(WORD_BITS - 1);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        low = BIT_AW'(i);
      end
    end
  end

  // one shifter serves both the allocate set and the free clear
  assign sh_amt = (op == OP_FREE) ? bit_sel : low;
  assign mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << sh_amt;

  assign res.full     = (word == FULL_WORD);
  assign res.low_bit  = low;
  assign res.new_word = (op == OP_FREE) ? (word & ~mask) : (word | mask);

endmodule

### hw/rtl/page_frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// Next-fit page frame allocator over a used-page bitmap of 32-bit words.
// ----------------------------------------------------------------------------
// Usage: send one transaction on in_ (in_op = 0 allocate, 1 free in_page_index).
// Each accepted transaction yields exactly one result on out_: out_status
// (0 done, 1 no free page, 2 free index out of range) and out_page_number
// (allocated page, zero otherwise).
// An allocate scans one bitmap word per cycle from the word of the last
// allocation, wrapping once; the bitmap read port sets that pace. A transaction
// goes from ST_IDLE through ST_SCAN, which examines one word at a time (one
// word for a free, at most 128 for a full bitmap), to ST_DONE, which loads
// its result into the output register; an out-of-range free skips ST_SCAN.
// A new transaction is taken only after the previous one has left ST_DONE.
// in_stall is high while a transaction is in progress. A result waiting in
// the output register under out_stall does not block acceptance, but the
// next result holds in the sequencer until the register is free.
// Reset (rst_n low, synchronous) marks every page free at once through
// per-word valid bits, rewinds the search pointer and drops any result.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [pfba_pkg::IDX_W-1:0]   in_page_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pfba_pkg::STAT_W-1:0]  out_status,
  output logic [pfba_pkg::IDX_W-1:0]   out_page_number
);
  import pfba_pkg::*;

  localparam int unsigned PAGE_W = WORD_AW + BIT_AW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic               op_r, op_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [WORD_AW-1:0] cur_w_r, cur_w_nxt;
  logic [WORD_AW-1:0] cnt_r, cnt_nxt;
  logic [WORD_AW-1:0] search_w_r, search_w_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [IDX_W-1:0]   res_page_r, res_page_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [IDX_W-1:0]   out_page_r, out_page_nxt;

  map_req_t             req;
  logic [WORD_BITS-1:0] rd_word;
  bit_res_t             bit_res;
  logic [WORD_AW-1:0]   next_w;
  logic [WORD_AW-1:0]   in_word;
  logic                 in_range_bad;
  logic [PAGE_W-1:0]    page_full;

  pfba_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_word (rd_word)
  );

  pfba_bit_unit u_bit (
    .word    (rd_word),
    .op      (op_r),
    .bit_sel (idx_r[BIT_AW-1:0]),
    .res     (bit_res)
  );

  assign next_w       = (cur_w_r == WORD_AW'(WORD_COUNT - 1)) ? '0 : cur_w_r + 1'b1;
  assign in_word      = WORD_AW'(in_page_index >> BIT_AW);
  assign in_range_bad = (32'(in_page_index) >= 32'(PAGE_LIMIT));
  assign page_full    = {cur_w_r, bit_res.low_bit};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    cur_w_nxt      = cur_w_r;
    cnt_nxt        = cnt_r;
    search_w_nxt   = search_w_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    req            = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_op;
          idx_nxt = in_page_index;
          cnt_nxt = '0;
          if (in_op == OP_ALLOC) begin
            req.rd_en   = 1'b1;
            req.rd_addr = search_w_r;
            cur_w_nxt   = search_w_r;
            state_nxt   = ST_SCAN;
          end else if (in_range_bad) begin
            res_status_nxt = STAT_RANGE;
            res_page_nxt   = '0;
            state_nxt      = ST_DONE;
          end else begin
            req.rd_en   = 1'b1;
            req.rd_addr = in_word;
            cur_w_nxt   = in_word;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (op_r == OP_FREE || !bit_res.full) begin
          req.wr_en      = 1'b1;
          req.wr_addr    = cur_w_r;
          req.wr_data    = bit_res.new_word;
          res_status_nxt = STAT_DONE;
          res_page_nxt   = '0;
          if (op_r == OP_ALLOC) begin
            search_w_nxt = cur_w_r;
            res_page_nxt = IDX_W'(page_full);
          end
          state_nxt = ST_DONE;
        end else if (cnt_r == WORD_AW'(WORD_COUNT - 1)) begin
          // swept every word once, bitmap is full
          res_status_nxt = STAT_NO_FREE;
          res_page_nxt   = '0;
          state_nxt      = ST_DONE;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = next_w;
          cur_w_nxt   = next_w;
          cnt_nxt     = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_page_nxt   = res_page_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      search_w_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      search_w_r  <= search_w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    cur_w_r      <= cur_w_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_page_number = out_page_r;

`ifndef SYNTHESIS
  a_free_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && op_r == OP_FREE) |=> (state_r == ST_DONE))
    else $error("free did not finish after one word");

  a_hit_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && op_r == OP_ALLOC && !bit_res.full) |=> (state_r == ST_DONE))
    else $error("scan continued past a word with a free page");

  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !(out_valid_r && out_stall)) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished transaction not moved to output register");

  a_fail_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_DONE) |-> (out_page_r == '0))
    else $error("nonzero page number on a failed transaction");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the page frame bitmap allocator. Allocate and free
// transactions are driven with random sender gaps and receiver stalls, with
// a long receiver hold-off. Every reply is predicted from a private copy of
// the used-page bitmap and the next-fit search pointer, and checked in order.
// ---------------------------------------------------------------------------
module testbench;
  import pfba_pkg::*;

  localparam int unsigned STALL_PCT      = 22;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 400;
  localparam int unsigned HOLD_CYCLES    = 90;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned IDX_SPAN       = 1 << IDX_W;

  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] page;
  } reply_t;

  class alloc_scoreboard;
    logic [WORD_BITS-1:0] used_map [WORD_COUNT];
    int unsigned          search_word;
    reply_t               pending_replies [$];
    int unsigned          failures;
    int unsigned          reports;

    function new();
      foreach (used_map[w]) used_map[w] = '0;
      search_word = 0;
      failures    = 0;
      reports     = 0;
    endfunction

    // next-fit allocation / free on the private bitmap copy
    function reply_t predict_reply(logic op, logic [IDX_W-1:0] idx);
      reply_t      r;
      int unsigned w;
      int unsigned n;
      int unsigned b;
      bit          found;
      r.status = STAT_DONE;
      r.page   = '0;
      if (op == OP_ALLOC) begin
        w = (search_word < WORD_COUNT) ? search_word : 0;
        found = 1'b0;
        for (n = 0; n < WORD_COUNT; n++) begin
          if (used_map[w] != FULL_WORD) begin
            found = 1'b1;
            break;
          end
          w = (w + 1) % WORD_COUNT;
        end
        if (found) begin
          b = 0;
          while (b < WORD_BITS - 1 && used_map[w][b]) b++;
          used_map[w][b] = 1'b1;
          search_word = w;
          r.page = IDX_W'(w * WORD_BITS + b);
        end else begin
          r.status = STAT_NO_FREE;
        end
      end else if (idx >= PAGE_LIMIT) begin
        r.status = STAT_RANGE;
      end else begin
        // a free never sets a bit, so freeing a free page is a no-op
        used_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
      end
      return r;
    endfunction

    function void note_request(logic op, logic [IDX_W-1:0] idx);
      pending_replies.push_back(predict_reply(op, idx));
    endfunction

    function void flag(string msg);
      failures++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("ERROR: %s", msg);
      end
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [IDX_W-1:0] page);
      reply_t want;
      if (pending_replies.size() == 0) begin
        flag($sformatf("unexpected reply status=%0d page=%0d", status, page));
        return;
      end
      want = pending_replies.pop_front();
      if (status !== want.status)
        flag($sformatf("status: expected %0d, got %0d", want.status, status));
      if (page !== want.page)
        flag($sformatf("page_number: expected %0d, got %0d", want.page, page));
    endfunction

    function logic [IDX_W-1:0] pick_used_page();
      logic [IDX_W-1:0] p;
      p = IDX_W'($urandom_range(IDX_SPAN - 1));
      repeat (64) begin
        if (p < PAGE_LIMIT && used_map[p / WORD_BITS][p % WORD_BITS]) return p;
        p = IDX_W'($urandom_range(IDX_SPAN - 1));
      end
      return p;
    endfunction
  endclass

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic              in_op           = OP_ALLOC;
  logic [IDX_W-1:0]  in_page_index   = '0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [IDX_W-1:0]  out_page_number;

  bit                tx_calm         = 1'b1;
  bit                rx_calm         = 1'b1;
  int unsigned       rx_hold         = 0;
  int unsigned       idle_cycles     = 0;

  alloc_scoreboard   sb = new();

  page_frame_bitmap_allocator dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_op,
    .in_page_index,
    .out_valid,
    .out_stall,
    .out_status,
    .out_page_number
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_request(logic op, logic [IDX_W-1:0] idx);
    if (!tx_calm && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_page_index <= idx;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(op, idx);
  endtask

  // frees mostly hit pages in use, the rest go to any index
  task automatic send_mix(int unsigned count, int unsigned alloc_pct);
    logic [IDX_W-1:0] idx;
    repeat (count) begin
      if ($urandom_range(99) < alloc_pct) begin
        send_request(OP_ALLOC, IDX_W'($urandom_range(IDX_SPAN - 1)));
      end else begin
        idx = ($urandom_range(99) < 75) ? sb.pick_used_page()
                                        : IDX_W'($urandom_range(IDX_SPAN - 1));
        send_request(OP_FREE, idx);
      end
    end
  endtask

  initial begin : receiver
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rx_hold != 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else if (rx_calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < STALL_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
      sb.check_result(out_status, out_page_number);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '1);        // index ignored on allocate
    send_request(OP_ALLOC, 12'h555);
    send_request(OP_FREE, 12'd1);
    send_request(OP_ALLOC, 12'hAAA);   // refills the lowest hole
    send_request(OP_FREE, '1);         // top page, never used
    send_request(OP_FREE, 12'h555);
    send_request(OP_FREE, 12'hAAA);
    send_request(OP_FREE, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 12'd2);
    send_request(OP_FREE, 12'd2);      // double free leaves the bit clear
    send_request(OP_ALLOC, '0);
    if (PAGE_LIMIT < IDX_SPAN) send_request(OP_FREE, IDX_W'(PAGE_LIMIT));

    // no idling on either side, allocation heavy so words fill and roll over
    send_mix(150, 85);

    tx_calm = 1'b0;
    rx_calm = 1'b0;
    send_mix(250, 65);

    // receiver holds off while the sender keeps offering
    tx_calm = 1'b1;
    rx_hold = HOLD_CYCLES;
    send_mix(40, 60);
    tx_calm = 1'b0;

    repeat (4) send_request(OP_ALLOC, IDX_W'($urandom_range(IDX_SPAN - 1)));

    // scattered frees, then a mixed run
    send_mix(40, 0);
    send_mix(300, 55);

    in_valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.failures += sb.pending_replies.size();
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
